/* rtl/lrl8_pkg.sv */
package lrl8_pkg;

  // request types on the input channel
  localparam logic [1:0] REQ_INSTR  = 2'd0;
  localparam logic [1:0] REQ_RDATA  = 2'd1;
  localparam logic [1:0] REQ_PRESET = 2'd2;

  // register slots
  localparam logic [2:0] R_B = 3'd0;
  localparam logic [2:0] R_C = 3'd1;
  localparam logic [2:0] R_D = 3'd2;
  localparam logic [2:0] R_E = 3'd3;
  localparam logic [2:0] R_H = 3'd4;
  localparam logic [2:0] R_L = 3'd5;
  localparam logic [2:0] R_M = 3'd6;  // (HL) operand code
  localparam logic [2:0] R_A = 3'd7;

  localparam int NUM_REGS = 8;

  // opcode groups and single opcodes
  localparam logic [1:0] X_MISC = 2'd0;
  localparam logic [1:0] X_MOVE = 2'd1;

  localparam logic [7:0] OP_HALT     = 8'h76;
  localparam logic [7:0] OP_LD_A_BC  = 8'h0A;
  localparam logic [7:0] OP_LD_A_DE  = 8'h1A;
  localparam logic [7:0] OP_LD_BC_A  = 8'h02;
  localparam logic [7:0] OP_LD_DE_A  = 8'h12;
  localparam logic [7:0] OP_LD_A_NN  = 8'hFA;
  localparam logic [7:0] OP_LD_NN_A  = 8'hEA;
  localparam logic [7:0] OP_LDH_A_N  = 8'hF0;
  localparam logic [7:0] OP_LDH_N_A  = 8'hE0;
  localparam logic [7:0] OP_LDH_A_C  = 8'hF2;
  localparam logic [7:0] OP_LDH_C_A  = 8'hE2;
  localparam logic [7:0] OP_LDI_HL_A = 8'h22;
  localparam logic [7:0] OP_LDI_A_HL = 8'h2A;
  localparam logic [7:0] OP_LDD_HL_A = 8'h32;
  localparam logic [7:0] OP_LDD_A_HL = 8'h3A;

  localparam logic [7:0] IO_BASE_HI = 8'hFF;

  // instruction clock counts
  localparam logic [4:0] CYC_NONE = 5'd0;
  localparam logic [4:0] CYC_4    = 5'd4;
  localparam logic [4:0] CYC_8    = 5'd8;
  localparam logic [4:0] CYC_12   = 5'd12;
  localparam logic [4:0] CYC_16   = 5'd16;

  // queue depths (powers of two)
  localparam int QDEPTH = 2;
  localparam int PTR_W  = $clog2(QDEPTH);
  localparam int CNT_W  = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALT    = 2'd1,
    ST_ILLEGAL = 2'd2,
    ST_STRAY   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    K_NOP,
    K_HALT,
    K_ILLEGAL,
    K_MOVE,
    K_LDIMM,
    K_LOAD,
    K_STORE,
    K_RDATA,
    K_PRESET
  } kind_t;

  typedef enum logic [2:0] {
    AS_HL,
    AS_BC,
    AS_DE,
    AS_NN,
    AS_IO_N,
    AS_IO_C
  } addr_sel_t;

  typedef enum logic [1:0] {
    HS_NONE,
    HS_INC,
    HS_DEC
  } hl_step_t;

  // classified item passed from front to back
  typedef struct packed {
    kind_t      kind;
    logic [2:0] dst;
    logic [2:0] src;
    logic       use_imm;
    addr_sel_t  addr_sel;
    hl_step_t   hl_step;
    logic [4:0] cycles;
    logic [7:0] byte_val;   // imm8 for instructions, data_in otherwise
    logic [15:0] imm16;
  } op_t;

  // result item
  typedef struct packed {
    status_t     status;
    logic        mem_read;
    logic        mem_write;
    logic [15:0] mem_addr;
    logic [7:0]  write_data;
    logic [4:0]  cycles;
    logic [7:0]  reg_a;
    logic [15:0] reg_hl;
  } res_t;

endpackage

/* rtl/lr35902_load8_execute_unit.sv */
// LR35902 8-bit load group execution unit.
// Input channel (push/full): req_type selects an instruction (opcode,
// imm8, imm16), a memory read-data return (data_in) or a register preset
// (reg_index, data_in). An item is taken on a clock edge with push high
// and full low.
// Result channel (empty/pop): one result per item, in order. The oldest
// result sits on the ports while empty is low and leaves on a clock edge
// with pop high. It carries status, any memory read or write request,
// the instruction clock count, and A and HL after the item.
// On acceptance an item is written into the decode queue; it is then
// executed and written into the result queue on an edge on which that
// queue has room, and from there it sits on the result ports.
// Throughput: one item per cycle while neither queue is full; each item
// is executed combinationally against the register file.
// A load from memory returns a read request; the following read-data item
// writes its destination register.
// When pop is held low, two results and two classified items are held,
// after which full rises; no item is lost.
// Reset (rst, synchronous) clears all registers, the pending read and
// both queues.
module lr35902_load8_execute_unit
  import lrl8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [7:0]  opcode,
  input  logic [7:0]  imm8,
  input  logic [15:0] imm16,
  input  logic [7:0]  data_in,
  input  logic [2:0]  reg_index,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status,
  output logic        mem_read,
  output logic        mem_write,
  output logic [15:0] mem_addr,
  output logic [7:0]  write_data,
  output logic [4:0]  cycles,
  output logic [7:0]  reg_a,
  output logic [15:0] reg_hl
);

  op_t  op;
  logic op_valid;
  logic op_take;
  res_t res;
  logic res_push;
  logic res_full;
  res_t res_out;

  lrl8_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .req_type  (req_type),
    .opcode    (opcode),
    .imm8      (imm8),
    .imm16     (imm16),
    .data_in   (data_in),
    .reg_index (reg_index),
    .op        (op),
    .op_valid  (op_valid),
    .op_take   (op_take)
  );

  lrl8_back u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .op_valid (op_valid),
    .op_take  (op_take),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full)
  );

  lrl8_result_q u_result_q (
    .clk      (clk),
    .rst      (rst),
    .res_in   (res),
    .res_push (res_push),
    .res_full (res_full),
    .res_out  (res_out),
    .empty    (empty),
    .pop      (pop)
  );

  // result fields onto the ports
  assign status     = res_out.status;
  assign mem_read   = res_out.mem_read;
  assign mem_write  = res_out.mem_write;
  assign mem_addr   = res_out.mem_addr;
  assign write_data = res_out.write_data;
  assign cycles     = res_out.cycles;
  assign reg_a      = res_out.reg_a;
  assign reg_hl     = res_out.reg_hl;

endmodule

/* rtl/lrl8_front.sv */
module lrl8_front
  import lrl8_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type,
  input  logic [7:0]  opcode,
  input  logic [7:0]  imm8,
  input  logic [15:0] imm16,
  input  logic [7:0]  data_in,
  input  logic [2:0]  reg_index,
  output op_t         op,
  output logic        op_valid,
  input  logic        op_take
);

  logic [1:0] x;
  logic [2:0] y;
  logic [2:0] z;
  op_t        dec;

  op_t              q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;

  assign x = opcode[7:6];
  assign y = opcode[5:3];
  assign z = opcode[2:0];

  // classify the incoming item
  always_comb begin
    dec          = '0;
    dec.kind     = K_NOP;
    dec.addr_sel = AS_HL;
    dec.hl_step  = HS_NONE;
    dec.cycles   = CYC_NONE;
    dec.imm16    = imm16;
    dec.byte_val = (req_type == REQ_INSTR) ? imm8 : data_in;
    unique case (req_type)
      REQ_INSTR: begin
        if (opcode == OP_HALT) begin
          dec.kind   = K_HALT;
          dec.cycles = CYC_4;
        end else if (x == X_MOVE) begin
          if (z == R_M) begin
            dec.kind   = K_LOAD;
            dec.dst    = y;
            dec.cycles = CYC_8;
          end else if (y == R_M) begin
            dec.kind   = K_STORE;
            dec.src    = z;
            dec.cycles = CYC_8;
          end else begin
            dec.kind   = K_MOVE;
            dec.dst    = y;
            dec.src    = z;
            dec.cycles = CYC_4;
          end
        end else if (x == X_MISC && z == R_M) begin
          if (y == R_M) begin
            dec.kind    = K_STORE;
            dec.use_imm = 1'b1;
            dec.cycles  = CYC_12;
          end else begin
            dec.kind   = K_LDIMM;
            dec.dst    = y;
            dec.cycles = CYC_8;
          end
        end else begin
          // accumulator loads and stores
          dec.dst = R_A;
          dec.src = R_A;
          unique case (opcode)
            OP_LD_A_BC: begin
              dec.kind = K_LOAD;  dec.addr_sel = AS_BC;   dec.cycles = CYC_8;
            end
            OP_LD_A_DE: begin
              dec.kind = K_LOAD;  dec.addr_sel = AS_DE;   dec.cycles = CYC_8;
            end
            OP_LD_BC_A: begin
              dec.kind = K_STORE; dec.addr_sel = AS_BC;   dec.cycles = CYC_8;
            end
            OP_LD_DE_A: begin
              dec.kind = K_STORE; dec.addr_sel = AS_DE;   dec.cycles = CYC_8;
            end
            OP_LD_A_NN: begin
              dec.kind = K_LOAD;  dec.addr_sel = AS_NN;   dec.cycles = CYC_16;
            end
            OP_LD_NN_A: begin
              dec.kind = K_STORE; dec.addr_sel = AS_NN;   dec.cycles = CYC_16;
            end
            OP_LDH_A_N: begin
              dec.kind = K_LOAD;  dec.addr_sel = AS_IO_N; dec.cycles = CYC_12;
            end
            OP_LDH_N_A: begin
              dec.kind = K_STORE; dec.addr_sel = AS_IO_N; dec.cycles = CYC_12;
            end
            OP_LDH_A_C: begin
              dec.kind = K_LOAD;  dec.addr_sel = AS_IO_C; dec.cycles = CYC_8;
            end
            OP_LDH_C_A: begin
              dec.kind = K_STORE; dec.addr_sel = AS_IO_C; dec.cycles = CYC_8;
            end
            OP_LDI_HL_A: begin
              dec.kind = K_STORE; dec.hl_step = HS_INC;   dec.cycles = CYC_8;
            end
            OP_LDI_A_HL: begin
              dec.kind = K_LOAD;  dec.hl_step = HS_INC;   dec.cycles = CYC_8;
            end
            OP_LDD_HL_A: begin
              dec.kind = K_STORE; dec.hl_step = HS_DEC;   dec.cycles = CYC_8;
            end
            OP_LDD_A_HL: begin
              dec.kind = K_LOAD;  dec.hl_step = HS_DEC;   dec.cycles = CYC_8;
            end
            default: begin
              dec.kind = K_ILLEGAL;
            end
          endcase
        end
      end
      REQ_RDATA: begin
        dec.kind = K_RDATA;
      end
      REQ_PRESET: begin
        dec.kind = K_PRESET;
        dec.dst  = reg_index;
      end
      default: begin
        dec.kind = K_NOP;
      end
    endcase
  end

  // decoupling queue towards the back end
  assign full     = (count == CNT_W'(QDEPTH));
  assign op_valid = (count != '0);
  assign op       = q[rd_ptr];
  assign do_push  = push && !full;

  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wr_ptr] <= dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (op_take) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (do_push && !op_take) begin
        count <= count + CNT_W'(1);
      end else if (!do_push && op_take) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_front_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(QDEPTH))
    else $error("front queue overfilled");

  a_front_take_nonempty: assert property (@(posedge clk) disable iff (rst)
    op_take |-> op_valid)
    else $error("back end took from an empty front queue");

endmodule

/* rtl/lrl8_back.sv */
module lrl8_back
  import lrl8_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  op_t  op,
  input  logic op_valid,
  output logic op_take,
  output res_t res,
  output logic res_push,
  input  logic res_full
);

  logic [7:0]  regs      [NUM_REGS];
  logic [7:0]  regs_next [NUM_REGS];
  logic        read_pending;
  logic        read_pending_next;
  logic [2:0]  pending_dest;
  logic [2:0]  pending_dest_next;

  logic [15:0] hl;
  logic [15:0] hl_stepped;
  logic [15:0] addr;
  logic [7:0]  store_data;

  assign op_take  = op_valid && !res_full;
  assign res_push = op_take;

  assign hl = {regs[R_H], regs[R_L]};

  // LDI/LDD pointer step, 16-bit wrap
  assign hl_stepped = hl + ((op.hl_step == HS_DEC) ? 16'hFFFF :
                            (op.hl_step == HS_INC) ? 16'h0001 : 16'h0000);

  // access address
  always_comb begin
    unique case (op.addr_sel)
      AS_HL:   addr = hl;
      AS_BC:   addr = {regs[R_B], regs[R_C]};
      AS_DE:   addr = {regs[R_D], regs[R_E]};
      AS_NN:   addr = op.imm16;
      AS_IO_N: addr = {IO_BASE_HI, op.byte_val};
      AS_IO_C: addr = {IO_BASE_HI, regs[R_C]};
      default: addr = hl;
    endcase
  end

  assign store_data = op.use_imm ? op.byte_val : regs[op.src];

  // execute the head item
  always_comb begin
    regs_next         = regs;
    read_pending_next = read_pending;
    pending_dest_next = pending_dest;
    res               = '0;
    res.status        = ST_OK;
    res.cycles        = op.cycles;
    unique case (op.kind)
      K_NOP: begin
      end
      K_HALT: begin
        res.status        = ST_HALT;
        read_pending_next = 1'b0;
      end
      K_ILLEGAL: begin
        res.status        = ST_ILLEGAL;
        read_pending_next = 1'b0;
      end
      K_MOVE: begin
        regs_next[op.dst] = regs[op.src];
        read_pending_next = 1'b0;
      end
      K_LDIMM: begin
        regs_next[op.dst] = op.byte_val;
        read_pending_next = 1'b0;
      end
      K_LOAD: begin
        res.mem_read      = 1'b1;
        res.mem_addr      = addr;
        regs_next[R_H]    = hl_stepped[15:8];
        regs_next[R_L]    = hl_stepped[7:0];
        read_pending_next = 1'b1;
        pending_dest_next = op.dst;
      end
      K_STORE: begin
        res.mem_write     = 1'b1;
        res.mem_addr      = addr;
        res.write_data    = store_data;
        regs_next[R_H]    = hl_stepped[15:8];
        regs_next[R_L]    = hl_stepped[7:0];
        read_pending_next = 1'b0;
      end
      K_RDATA: begin
        if (read_pending) begin
          regs_next[pending_dest] = op.byte_val;
          read_pending_next       = 1'b0;
        end else begin
          res.status = ST_STRAY;
        end
      end
      K_PRESET: begin
        regs_next[op.dst] = op.byte_val;
      end
      default: begin
      end
    endcase
    res.reg_a  = regs_next[R_A];
    res.reg_hl = {regs_next[R_H], regs_next[R_L]};
  end

  // register file and pending-read state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_REGS; i++) begin
        regs[i] <= '0;
      end
      read_pending <= 1'b0;
      pending_dest <= '0;
    end else if (op_take) begin
      regs         <= regs_next;
      read_pending <= read_pending_next;
      pending_dest <= pending_dest_next;
    end
  end

  a_back_load_arms: assert property (@(posedge clk) disable iff (rst)
    (op_take && op.kind == K_LOAD) |=> read_pending)
    else $error("memory load did not leave a read pending");

  a_back_rdata_clears: assert property (@(posedge clk) disable iff (rst)
    (op_take && op.kind == K_RDATA) |=> !read_pending)
    else $error("read data left a read pending");

  a_back_preset_holds: assert property (@(posedge clk) disable iff (rst)
    (op_take && op.kind == K_PRESET) |=> $stable(read_pending))
    else $error("preset disturbed the pending read");

endmodule

/* rtl/lrl8_result_q.sv */
module lrl8_result_q
  import lrl8_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  res_t res_in,
  input  logic res_push,
  output logic res_full,
  output res_t res_out,
  output logic empty,
  input  logic pop
);

  res_t             q [QDEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_pop;

  assign res_full = (count == CNT_W'(QDEPTH));
  assign empty    = (count == '0);
  assign res_out  = q[rd_ptr];
  assign do_pop   = pop && !empty;

  // result storage
  always_ff @(posedge clk) begin
    if (res_push) begin
      q[wr_ptr] <= res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (res_push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      if (res_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (!res_push && do_pop) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  a_resq_no_overflow: assert property (@(posedge clk) disable iff (rst)
    res_push |-> !res_full)
    else $error("result pushed into a full queue");

endmodule
